// File: sv/mhrs_pkg.sv
// Types, widths, codes and trig table helpers for the min-height rotation search.
// Used by the top level, the trig ROM and the dot unit; no dependencies.
`default_nettype none

package mhrs_pkg;

   localparam int PT_W      = 32;
   localparam int COEF_W    = 17;
   localparam int PROD_W    = 49;
   localparam int SUM_W     = 50;
   localparam int STORE_W   = 34;
   localparam int HEIGHT_W  = 34;
   localparam int IDX_OUT_W = 8;
   localparam int OP_W      = 2;
   localparam int RND_SHIFT = 15;

   localparam logic [OP_W-1:0] OP_ACC = 2'd0;
   localparam logic [OP_W-1:0] OP_SEL = 2'd1;
   localparam logic [OP_W-1:0] OP_ROT = 2'd2;

   localparam logic KIND_SEL = 1'b0;
   localparam logic KIND_ROT = 1'b1;

   localparam logic signed [STORE_W-1:0] STORE_MAX = 34'sh1_FFFF_FFFF;
   localparam logic signed [STORE_W-1:0] STORE_MIN = 34'sh2_0000_0000;
   localparam logic [PT_W-1:0] SAT_POS = 32'h7FFF_FFFF;
   localparam logic [PT_W-1:0] SAT_NEG = 32'h8000_0000;
   localparam logic signed [SUM_W-1:0] ROUND_BIAS = 50'sd16384;

   localparam longint unsigned PI_Q30  = 64'd3373259426;
   localparam longint          ONE_Q30 = 64'sd1073741824;

   function automatic logic [63:0] mul_q30(input logic [63:0] a, input logic [63:0] b);
      logic [63:0] p;
      p = a * b;
      return p >> 30;
   endfunction

   function automatic logic [15:0] q30_to_q15(input longint s);
      longint c;
      longint r;
      c = s;
      if (c < 0) c = 0;
      if (c > ONE_Q30) c = ONE_Q30;
      r = (c + 64'sd16384) >>> 15;
      return r[15:0];
   endfunction

   function automatic logic [15:0] sin_q15(input logic [63:0] x);
      logic [63:0] x2;
      logic [63:0] term;
      longint      s;
      x2   = mul_q30(x, x);
      s    = longint'(x);
      term = mul_q30(x, x2) / 64'd6;
      s    = s - longint'(term);
      term = mul_q30(term, x2) / 64'd20;
      s    = s + longint'(term);
      term = mul_q30(term, x2) / 64'd42;
      s    = s - longint'(term);
      term = mul_q30(term, x2) / 64'd72;
      s    = s + longint'(term);
      term = mul_q30(term, x2) / 64'd110;
      s    = s - longint'(term);
      return q30_to_q15(s);
   endfunction

   function automatic logic [15:0] cos_q15(input logic [63:0] x);
      logic [63:0] x2;
      logic [63:0] term;
      longint      c;
      x2   = mul_q30(x, x);
      c    = ONE_Q30;
      term = mul_q30(64'(ONE_Q30), x2) / 64'd2;
      c    = c - longint'(term);
      term = mul_q30(term, x2) / 64'd12;
      c    = c + longint'(term);
      term = mul_q30(term, x2) / 64'd30;
      c    = c - longint'(term);
      term = mul_q30(term, x2) / 64'd56;
      c    = c + longint'(term);
      term = mul_q30(term, x2) / 64'd90;
      c    = c - longint'(term);
      term = mul_q30(term, x2) / 64'd132;
      c    = c + longint'(term);
      return q30_to_q15(c);
   endfunction

endpackage

`default_nettype wire

// File: sv/min_height_rotation_search.sv
// Accumulate: one angle a cycle through the shared multiply-add unit, then its two pipeline
// stages; ready again once the last angle is stored; ignored words leave it idle.
// Select: one store read a cycle, then result and ready; an empty set skips the scan.
// Rotate: ru then rv; pass-through points skip. One word at a time; select and rotate wait
// while an earlier result is unaccepted, then leave it in the output register and go idle.
// Synchronous reset clears the store and selects the identity rotation; no clearing pass.
`default_nettype none

module min_height_rotation_search #(
   parameter int NUM_ROTATIONS = 32
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_valid,
   output logic                                       req_ready,
   input  wire logic [mhrs_pkg::OP_W-1:0]             req_op,
   input  wire logic signed [mhrs_pkg::PT_W-1:0]      req_point_u,
   input  wire logic signed [mhrs_pkg::PT_W-1:0]      req_point_v,
   input  wire logic                                  req_point_real,
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_ready,
   output logic                                       rsp_kind,
   output logic signed [mhrs_pkg::PT_W-1:0]           rsp_rotated_u,
   output logic signed [mhrs_pkg::PT_W-1:0]           rsp_rotated_v,
   output logic [mhrs_pkg::IDX_OUT_W-1:0]             rsp_best_index,
   output logic [mhrs_pkg::HEIGHT_W-1:0]              rsp_best_height,
   output logic                                       rsp_empty_set
);
   import mhrs_pkg::*;

   localparam int IDX_W = (NUM_ROTATIONS > 1) ? $clog2(NUM_ROTATIONS) : 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_ROTATIONS - 1);
   localparam int RAM_W = 2 * STORE_W;

   localparam int ST_W = 3;
   localparam logic [ST_W-1:0] S_IDLE     = 3'd0;
   localparam logic [ST_W-1:0] S_ACC      = 3'd1;
   localparam logic [ST_W-1:0] S_ACC_DRN  = 3'd2;
   localparam logic [ST_W-1:0] S_SEL_SCAN = 3'd3;
   localparam logic [ST_W-1:0] S_SEL_DRN  = 3'd4;
   localparam logic [ST_W-1:0] S_SEL_DONE = 3'd5;
   localparam logic [ST_W-1:0] S_ROT      = 3'd6;
   localparam logic [ST_W-1:0] S_OUT      = 3'd7;

   logic [ST_W-1:0]           state_ff, state_in;
   logic [IDX_W-1:0]          cnt_ff, cnt_in;
   logic signed [PT_W-1:0]    u_ff, u_in;
   logic signed [PT_W-1:0]    v_ff, v_in;
   logic                      any_seen_ff, any_seen_in;
   logic [IDX_W-1:0]          chosen_ff, chosen_in;
   logic [NUM_ROTATIONS-1:0]  vld_ff, vld_in;
   logic                      kind_ff, kind_in;
   logic                      empty_ff, empty_in;
   logic signed [STORE_W-1:0] ru_ff, ru_in;
   logic signed [STORE_W-1:0] rv_ff, rv_in;
   logic [HEIGHT_W-1:0]       best_h_ff, best_h_in;
   logic [IDX_W-1:0]          best_idx_ff, best_idx_in;
   logic                      rd_pend_ff;
   logic [IDX_W-1:0]          rd_idx_ff;
   logic                      h_vld_ff;
   logic [IDX_W-1:0]          h_idx_ff;
   logic [HEIGHT_W-1:0]       h_ff, h_in;

   logic                      rsp_valid_ff, rsp_valid_in;
   logic                      rsp_kind_ff, rsp_kind_in;
   logic [PT_W-1:0]           rsp_u_ff, rsp_u_in;
   logic [PT_W-1:0]           rsp_v_ff, rsp_v_in;
   logic [IDX_OUT_W-1:0]      rsp_idx_ff, rsp_idx_in;
   logic [HEIGHT_W-1:0]       rsp_h_ff, rsp_h_in;
   logic                      rsp_empty_ff, rsp_empty_in;

   logic                      accept;
   logic [IDX_W-1:0]          rom_idx;
   logic signed [COEF_W-1:0]  cos_val, sin_val;
   logic                      dot_issue;
   logic signed [COEF_W-1:0]  coef_a, coef_b;
   logic                      p1_valid, res_valid;
   logic [IDX_W-1:0]          p1_tag, res_tag;
   logic signed [STORE_W-1:0] res_value;

   logic                      ram_wr_en, ram_rd_en;
   logic [IDX_W-1:0]          ram_rd_addr;
   logic [RAM_W-1:0]          ram_wr_data, ram_rd_data;
   logic signed [STORE_W-1:0] cur_low, cur_high, new_low, new_high;
   logic signed [STORE_W:0]   h_diff;
   logic                      out_free;
   logic [PT_W-1:0]           sat_u, sat_v;

   mhrs_trig_rom #(.NUM_ROTATIONS(NUM_ROTATIONS)) u_rom (
      .idx     (rom_idx),
      .cos_val (cos_val),
      .sin_val (sin_val)
   );

   mhrs_dot_unit #(.TAG_W(IDX_W)) u_dot (
      .clock     (clock),
      .reset     (reset),
      .issue     (dot_issue),
      .issue_tag (cnt_ff),
      .coef_a    (coef_a),
      .coef_b    (coef_b),
      .pt_u      (u_ff),
      .pt_v      (v_ff),
      .p1_valid  (p1_valid),
      .p1_tag    (p1_tag),
      .res_valid (res_valid),
      .res_tag   (res_tag),
      .res_value (res_value)
   );

   mhrs_ram #(.WIDTH(RAM_W), .DEPTH(NUM_ROTATIONS)) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (res_tag),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign accept    = req_valid && req_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign out_free  = !rsp_valid_ff || rsp_ready;

   // shared unit operands: accumulate wants rv only; rotate wants ru then rv
   always_comb begin
      rom_idx   = (state_ff == S_ROT) ? chosen_ff : cnt_ff;
      dot_issue = (state_ff == S_ACC) ||
                  ((state_ff == S_ROT) && ((cnt_ff == '0) || (p1_valid && p1_tag == '0)));
      if (state_ff == S_ROT && cnt_ff == '0) begin
         coef_a = cos_val;
         coef_b = -sin_val;
      end else begin
         coef_a = sin_val;
         coef_b = cos_val;
      end
   end

   // store update and scan
   always_comb begin
      ram_rd_en   = (state_ff == S_SEL_SCAN) ||
                    (p1_valid && (state_ff == S_ACC || state_ff == S_ACC_DRN));
      ram_rd_addr = (state_ff == S_SEL_SCAN) ? cnt_ff : p1_tag;
      ram_wr_en   = res_valid && (state_ff == S_ACC || state_ff == S_ACC_DRN);
      cur_low     = vld_ff[res_tag] ? $signed(ram_rd_data[STORE_W-1:0]) : STORE_MAX;
      cur_high    = vld_ff[res_tag] ? $signed(ram_rd_data[RAM_W-1:STORE_W]) : STORE_MIN;
      new_low     = (res_value < cur_low) ? res_value : cur_low;
      new_high    = (res_value > cur_high) ? res_value : cur_high;
      ram_wr_data = {new_high, new_low};
      h_diff      = {ram_rd_data[RAM_W-1], ram_rd_data[RAM_W-1:STORE_W]} -
                    {ram_rd_data[STORE_W-1], ram_rd_data[STORE_W-1:0]};
      h_in        = h_diff[HEIGHT_W-1:0];
   end

   always_comb begin
      sat_u = ((ru_ff[STORE_W-1:PT_W-1] == '0) || (ru_ff[STORE_W-1:PT_W-1] == '1)) ?
              ru_ff[PT_W-1:0] : (ru_ff[STORE_W-1] ? SAT_NEG : SAT_POS);
      sat_v = ((rv_ff[STORE_W-1:PT_W-1] == '0) || (rv_ff[STORE_W-1:PT_W-1] == '1)) ?
              rv_ff[PT_W-1:0] : (rv_ff[STORE_W-1] ? SAT_NEG : SAT_POS);
   end

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      u_in         = u_ff;
      v_in         = v_ff;
      any_seen_in  = any_seen_ff;
      chosen_in    = chosen_ff;
      vld_in       = vld_ff;
      kind_in      = kind_ff;
      empty_in     = empty_ff;
      ru_in        = ru_ff;
      rv_in        = rv_ff;
      best_h_in    = best_h_ff;
      best_idx_in  = best_idx_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_kind_in  = rsp_kind_ff;
      rsp_u_in     = rsp_u_ff;
      rsp_v_in     = rsp_v_ff;
      rsp_idx_in   = rsp_idx_ff;
      rsp_h_in     = rsp_h_ff;
      rsp_empty_in = rsp_empty_ff;

      if (ram_wr_en) vld_in[res_tag] = 1'b1;

      if (h_vld_ff) begin
         if (h_idx_ff == '0 || h_ff < best_h_ff) begin
            best_h_in   = h_ff;
            best_idx_in = h_idx_ff;
         end
      end

      if (res_valid && state_ff == S_ROT) begin
         if (res_tag == '0) ru_in = res_value;
         else               rv_in = res_value;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               u_in   = req_point_u;
               v_in   = req_point_v;
               cnt_in = '0;
               unique case (req_op)
                  OP_ACC: begin
                     if (req_point_real) begin
                        any_seen_in = 1'b1;
                        state_in    = S_ACC;
                     end
                  end
                  OP_SEL: begin
                     kind_in  = KIND_SEL;
                     empty_in = !any_seen_ff;
                     if (any_seen_ff) begin
                        state_in = S_SEL_SCAN;
                     end else begin
                        best_h_in   = '0;
                        best_idx_in = '0;
                        state_in    = S_SEL_DONE;
                     end
                  end
                  OP_ROT: begin
                     kind_in = KIND_ROT;
                     if (req_point_real) begin
                        state_in = S_ROT;
                     end else begin
                        ru_in    = STORE_W'(req_point_u);
                        rv_in    = STORE_W'(req_point_v);
                        state_in = S_OUT;
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_ACC: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == LAST_IDX) state_in = S_ACC_DRN;
         end
         S_ACC_DRN: begin
            if (res_valid && res_tag == LAST_IDX) state_in = S_IDLE;
         end
         S_SEL_SCAN: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == LAST_IDX) state_in = S_SEL_DRN;
         end
         S_SEL_DRN: begin
            if (h_vld_ff && h_idx_ff == LAST_IDX) state_in = S_SEL_DONE;
         end
         S_SEL_DONE: begin
            chosen_in   = best_idx_ff;
            vld_in      = '0;
            any_seen_in = 1'b0;
            state_in    = S_OUT;
         end
         S_ROT: begin
            if (cnt_ff == '0) cnt_in = IDX_W'(1);
            if (res_valid && res_tag != '0) state_in = S_OUT;
         end
         S_OUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = kind_ff;
               rsp_u_in     = (kind_ff == KIND_ROT) ? sat_u : '0;
               rsp_v_in     = (kind_ff == KIND_ROT) ? sat_v : '0;
               rsp_idx_in   = (kind_ff == KIND_SEL) ? IDX_OUT_W'(best_idx_ff) : '0;
               rsp_h_in     = (kind_ff == KIND_SEL) ? best_h_ff : '0;
               rsp_empty_in = (kind_ff == KIND_SEL) && empty_ff;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         any_seen_ff  <= 1'b0;
         chosen_ff    <= '0;
         vld_ff       <= '0;
         rd_pend_ff   <= 1'b0;
         h_vld_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         any_seen_ff  <= any_seen_in;
         chosen_ff    <= chosen_in;
         vld_ff       <= vld_in;
         rd_pend_ff   <= (state_ff == S_SEL_SCAN);
         h_vld_ff     <= rd_pend_ff;
         rsp_valid_ff <= rsp_valid_in;
      end
      u_ff         <= u_in;
      v_ff         <= v_in;
      kind_ff      <= kind_in;
      empty_ff     <= empty_in;
      ru_ff        <= ru_in;
      rv_ff        <= rv_in;
      best_h_ff    <= best_h_in;
      best_idx_ff  <= best_idx_in;
      rd_idx_ff    <= cnt_ff;
      h_idx_ff     <= rd_idx_ff;
      h_ff         <= h_in;
      rsp_kind_ff  <= rsp_kind_in;
      rsp_u_ff     <= rsp_u_in;
      rsp_v_ff     <= rsp_v_in;
      rsp_idx_ff   <= rsp_idx_in;
      rsp_h_ff     <= rsp_h_in;
      rsp_empty_ff <= rsp_empty_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_kind        = rsp_kind_ff;
   assign rsp_rotated_u   = rsp_u_ff;
   assign rsp_rotated_v   = rsp_v_ff;
   assign rsp_best_index  = rsp_idx_ff;
   assign rsp_best_height = rsp_h_ff;
   assign rsp_empty_set   = rsp_empty_ff;

   a_res_in_work: assert property (@(posedge clock) disable iff (reset)
      res_valid |-> (state_ff == S_ACC || state_ff == S_ACC_DRN || state_ff == S_ROT))
      else $error("rotation result outside accumulate or rotate");

   a_no_write_sel: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SEL_SCAN || state_ff == S_SEL_DRN || state_ff == S_SEL_DONE)
      |-> !ram_wr_en)
      else $error("store written during select");

   a_sel_clears: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SEL_DONE) |=> (!any_seen_ff && vld_ff == '0))
      else $error("store not cleared after select");

   a_chosen_range: assert property (@(posedge clock) disable iff (reset)
      chosen_ff <= LAST_IDX)
      else $error("chosen angle out of range");

endmodule

`default_nettype wire

// File: sv/mhrs_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module mhrs_ram #(
   parameter int WIDTH = 68,
   parameter int DEPTH = 32
) (
   input  wire logic                                       clock,
   input  wire logic                                       wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                           wr_data,
   input  wire logic                                       rd_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                                rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_addr] <= wr_data;
      if (rd_en) rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: sv/mhrs_trig_rom.sv
// Constant Q1.15 cosine/sine table over NUM_ROTATIONS angles in half a turn.
// Depends on mhrs_pkg for the series evaluation at elaboration.
`default_nettype none

module mhrs_trig_rom #(
   parameter int NUM_ROTATIONS = 32
) (
   input  wire logic [((NUM_ROTATIONS > 1) ? $clog2(NUM_ROTATIONS) : 1)-1:0] idx,
   output logic signed [mhrs_pkg::COEF_W-1:0]                               cos_val,
   output logic signed [mhrs_pkg::COEF_W-1:0]                               sin_val
);
   import mhrs_pkg::*;

   logic signed [COEF_W-1:0] cos_tab [NUM_ROTATIONS];
   logic signed [COEF_W-1:0] sin_tab [NUM_ROTATIONS];

   for (genvar g = 0; g < NUM_ROTATIONS; g++) begin : g_entry
      localparam bit FLIP = (2 * g) > NUM_ROTATIONS;
      localparam longint unsigned J = FLIP ? longint'(NUM_ROTATIONS - g) : longint'(g);
      localparam longint unsigned X = (PI_Q30 * J) / NUM_ROTATIONS;
      localparam logic signed [COEF_W-1:0] C_POS = COEF_W'(cos_q15(X));
      localparam logic signed [COEF_W-1:0] S_POS = COEF_W'(sin_q15(X));
      assign cos_tab[g] = FLIP ? -C_POS : C_POS;
      assign sin_tab[g] = S_POS;
   end

   assign cos_val = cos_tab[idx];
   assign sin_val = sin_tab[idx];

endmodule

`default_nettype wire

// File: sv/mhrs_dot_unit.sv
// Shared rotation unit: a*u + b*v, rounded half up from Q.31 to Q17.16.
// Two pipeline stages (products, then sum and round); depends on mhrs_pkg.
`default_nettype none

module mhrs_dot_unit #(
   parameter int TAG_W = 5
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 issue,
   input  wire logic [TAG_W-1:0]                     issue_tag,
   input  wire logic signed [mhrs_pkg::COEF_W-1:0]   coef_a,
   input  wire logic signed [mhrs_pkg::COEF_W-1:0]   coef_b,
   input  wire logic signed [mhrs_pkg::PT_W-1:0]     pt_u,
   input  wire logic signed [mhrs_pkg::PT_W-1:0]     pt_v,
   output logic                                      p1_valid,
   output logic [TAG_W-1:0]                          p1_tag,
   output logic                                      res_valid,
   output logic [TAG_W-1:0]                          res_tag,
   output logic signed [mhrs_pkg::STORE_W-1:0]       res_value
);
   import mhrs_pkg::*;

   logic                      p1_valid_ff;
   logic [TAG_W-1:0]          p1_tag_ff;
   logic signed [PROD_W-1:0]  prod_a_ff;
   logic signed [PROD_W-1:0]  prod_b_ff;
   logic                      res_valid_ff;
   logic [TAG_W-1:0]          res_tag_ff;
   logic signed [STORE_W-1:0] res_value_ff;

   logic signed [PROD_W-1:0]  prod_a_in;
   logic signed [PROD_W-1:0]  prod_b_in;
   logic signed [SUM_W-1:0]   sum_w;
   logic signed [SUM_W-1:0]   rnd_w;

   always_comb begin
      prod_a_in = PROD_W'(coef_a) * PROD_W'(pt_u);
      prod_b_in = PROD_W'(coef_b) * PROD_W'(pt_v);
      sum_w     = SUM_W'(prod_a_ff) + SUM_W'(prod_b_ff) + ROUND_BIAS;
      rnd_w     = sum_w >>> RND_SHIFT;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff  <= 1'b0;
         res_valid_ff <= 1'b0;
      end else begin
         p1_valid_ff  <= issue;
         res_valid_ff <= p1_valid_ff;
      end
      p1_tag_ff    <= issue_tag;
      prod_a_ff    <= prod_a_in;
      prod_b_ff    <= prod_b_in;
      res_tag_ff   <= p1_tag_ff;
      res_value_ff <= rnd_w[STORE_W-1:0];
   end

   assign p1_valid  = p1_valid_ff;
   assign p1_tag    = p1_tag_ff;
   assign res_valid = res_valid_ff;
   assign res_tag   = res_tag_ff;
   assign res_value = res_value_ff;

endmodule

`default_nettype wire

// File: dv/tb.sv
// Testbench for min_height_rotation_search: directed and random words checked against
// an in-bench model of the angle table, the per-angle v extents and the chosen rotation.
// Depends on mhrs_pkg and the RTL top level only.
`default_nettype none

module tb;
   import mhrs_pkg::*;

   localparam int NUM_ROTATIONS = 32;
   localparam int STALL_LIMIT = 4000;
   localparam logic [OP_W-1:0] OP_NONE = 2'd3;
   localparam longint unsigned HALF_TURN_Q30 = 64'd3373259426;
   localparam longint UNIT_Q30 = 64'sd1073741824;
   localparam longint LOW_INIT = 64'sd8589934591;
   localparam longint HIGH_INIT = -64'sd8589934592;

   typedef struct packed {
      logic                   kind;
      logic [PT_W-1:0]        ru;
      logic [PT_W-1:0]        rv;
      logic [IDX_OUT_W-1:0]   idx;
      logic [HEIGHT_W-1:0]    height;
      logic                   empty;
   } word_out_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [OP_W-1:0] req_op = OP_ACC;
   logic signed [PT_W-1:0] req_point_u = '0;
   logic signed [PT_W-1:0] req_point_v = '0;
   logic req_point_real = 1'b0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic rsp_kind;
   logic signed [PT_W-1:0] rsp_rotated_u;
   logic signed [PT_W-1:0] rsp_rotated_v;
   logic [IDX_OUT_W-1:0] rsp_best_index;
   logic [HEIGHT_W-1:0] rsp_best_height;
   logic rsp_empty_set;

   int cos_lut [NUM_ROTATIONS];
   int sin_lut [NUM_ROTATIONS];
   longint low_v [NUM_ROTATIONS];
   longint high_v [NUM_ROTATIONS];
   bit any_seen;
   int chosen;

   word_out_type report_q [$];
   int fault_count = 0;
   int quiet_cycles = 0;
   int sender_idle_pct = 0;
   int receiver_idle_pct = 0;

   min_height_rotation_search #(.NUM_ROTATIONS(NUM_ROTATIONS)) uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_op(req_op),
      .req_point_u(req_point_u),
      .req_point_v(req_point_v),
      .req_point_real(req_point_real),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_kind(rsp_kind),
      .rsp_rotated_u(rsp_rotated_u),
      .rsp_rotated_v(rsp_rotated_v),
      .rsp_best_index(rsp_best_index),
      .rsp_best_height(rsp_best_height),
      .rsp_empty_set(rsp_empty_set)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int to_q15(longint s);
      longint c;
      c = s;
      if (c < 0) c = 0;
      if (c > UNIT_Q30) c = UNIT_Q30;
      return int'((c + 64'sd16384) >>> 15);
   endfunction

   // Taylor series per angle, mirrored about a quarter turn
   function automatic void build_trig();
      bit flip;
      longint unsigned j, x, x2, term;
      longint s, c;
      for (int i = 0; i < NUM_ROTATIONS; i++) begin
         flip = (2 * i) > NUM_ROTATIONS;
         j = flip ? longint'(NUM_ROTATIONS - i) : longint'(i);
         x = (HALF_TURN_Q30 * j) / NUM_ROTATIONS;
         x2 = (x * x) >> 30;
         term = x;
         s = longint'(x);
         for (int k = 1; k <= 5; k++) begin
            term = ((term * x2) >> 30) / longint'((2 * k) * (2 * k + 1));
            s = (k % 2 == 1) ? s - longint'(term) : s + longint'(term);
         end
         term = UNIT_Q30;
         c = UNIT_Q30;
         for (int k = 1; k <= 6; k++) begin
            term = ((term * x2) >> 30) / longint'((2 * k - 1) * (2 * k));
            c = (k % 2 == 1) ? c - longint'(term) : c + longint'(term);
         end
         sin_lut[i] = to_q15(s);
         cos_lut[i] = flip ? -to_q15(c) : to_q15(c);
      end
   endfunction

   function automatic void clear_sets();
      for (int i = 0; i < NUM_ROTATIONS; i++) begin
         low_v[i] = LOW_INIT;
         high_v[i] = HIGH_INIT;
      end
      any_seen = 1'b0;
   endfunction

   function automatic void turn_point(int a, longint u, longint v,
                                      output longint ru, output longint rv);
      longint c, s;
      c = cos_lut[a];
      s = sin_lut[a];
      ru = (c * u - s * v + 64'sd16384) >>> 15;
      rv = (s * u + c * v + 64'sd16384) >>> 15;
   endfunction

   function automatic logic [PT_W-1:0] clamp32(longint x);
      if (x > 64'sd2147483647) return SAT_POS;
      if (x < -64'sd2147483648) return SAT_NEG;
      return x[PT_W-1:0];
   endfunction

   // Applies one word to the model state; returns 1 when the word yields a result.
   function automatic bit search_step(logic [OP_W-1:0] op, logic signed [PT_W-1:0] pu,
                                      logic signed [PT_W-1:0] pv, logic real_pt,
                                      output word_out_type r);
      longint u, v, ru, rv, h, best_h;
      int best;
      bit was_empty;
      u = longint'(pu);
      v = longint'(pv);
      r = '0;
      case (op)
         OP_ACC: begin
            if (real_pt) begin
               for (int i = 0; i < NUM_ROTATIONS; i++) begin
                  turn_point(i, u, v, ru, rv);
                  if (rv < low_v[i]) low_v[i] = rv;
                  if (rv > high_v[i]) high_v[i] = rv;
               end
               any_seen = 1'b1;
            end
            return 1'b0;
         end
         OP_SEL: begin
            best = 0;
            best_h = 0;
            was_empty = !any_seen;
            if (any_seen) begin
               best_h = high_v[0] - low_v[0];
               for (int i = 1; i < NUM_ROTATIONS; i++) begin
                  h = high_v[i] - low_v[i];
                  if (h < best_h) begin
                     best_h = h;
                     best = i;
                  end
               end
            end
            chosen = best;
            clear_sets();
            r.kind = KIND_SEL;
            r.idx = best[IDX_OUT_W-1:0];
            r.height = best_h[HEIGHT_W-1:0];
            r.empty = was_empty;
            return 1'b1;
         end
         OP_ROT: begin
            ru = u;
            rv = v;
            if (real_pt) turn_point(chosen, u, v, ru, rv);
            r.kind = KIND_ROT;
            r.ru = clamp32(ru);
            r.rv = clamp32(rv);
            return 1'b1;
         end
         default: return 1'b0;
      endcase
   endfunction

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= receiver_idle_pct);
   end

   always @(posedge clock) begin : monitor
      word_out_type want, got;
      bit moved;
      if (!reset) begin
         moved = 1'b0;
         if (req_valid && req_ready) begin
            moved = 1'b1;
            if (search_step(req_op, req_point_u, req_point_v, req_point_real, want))
               report_q.push_back(want);
         end
         if (rsp_valid && rsp_ready) begin
            moved = 1'b1;
            got = '{rsp_kind, rsp_rotated_u, rsp_rotated_v, rsp_best_index,
                    rsp_best_height, rsp_empty_set};
            if (report_q.size() == 0) begin
               fault_count++;
               if (fault_count <= 10)
                  $display("unexpected result word: %p", got);
            end else begin
               want = report_q.pop_front();
               if (got !== want) begin
                  fault_count++;
                  if (fault_count <= 10) begin
                     $display("mismatch kind %0d/%0d u %h/%h v %h/%h",
                              want.kind, got.kind, want.ru, got.ru, want.rv, got.rv);
                     $display("  index %0d/%0d height %h/%h empty %0d/%0d (exp/act)",
                              want.idx, got.idx, want.height, got.height,
                              want.empty, got.empty);
                  end
               end
            end
         end
         quiet_cycles = moved ? 0 : quiet_cycles + 1;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
            $display("CHECKS FAILED");
            $finish;
         end
      end
   end

   // Called at a rising edge; returns at the edge that takes the word.
   task automatic send_word(logic [OP_W-1:0] op, logic [PT_W-1:0] u, logic [PT_W-1:0] v,
                            logic real_pt);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_op <= op;
      req_point_u <= u;
      req_point_v <= v;
      req_point_real <= real_pt;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic hold_until_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (report_q.size() != 0);
   endtask

   function automatic logic [PT_W-1:0] rand_coord();
      int pick;
      pick = $urandom_range(99);
      if (pick < 10) begin
         case ($urandom_range(4))
            0: return SAT_POS;
            1: return SAT_NEG;
            2: return '0;
            3: return '1;
            default: return 32'h0000_0001;
         endcase
      end
      if (pick < 55) return $urandom_range(0, 32'h003F_FFFF) - 32'h0020_0000;
      return $urandom();
   endfunction

   task automatic test_identity_rotation();
      send_word(OP_ROT, SAT_POS, SAT_NEG, 1'b1);
      send_word(OP_ROT, SAT_NEG, SAT_POS, 1'b1);
      send_word(OP_ROT, '0, '0, 1'b1);
      send_word(OP_ROT, '1, 32'h0000_0001, 1'b0);
      send_word(OP_ROT, SAT_NEG, SAT_NEG, 1'b0);
   endtask

   task automatic test_empty_select();
      send_word(OP_SEL, '0, '0, 1'b1);
      send_word(OP_NONE, SAT_POS, SAT_POS, 1'b1);
      send_word(OP_ACC, 32'h0000_1234, 32'h0000_5678, 1'b0);
      send_word(OP_SEL, '0, '0, 1'b0);
   endtask

   task automatic test_tied_heights();
      send_word(OP_ACC, 32'h0001_0000, 32'h0002_0000, 1'b1);
      send_word(OP_SEL, '0, '0, 1'b1);
      send_word(OP_ACC, 32'hFFF3_0000, 32'h0005_8000, 1'b1);
      send_word(OP_ACC, 32'hFFF3_0000, 32'h0005_8000, 1'b1);
      send_word(OP_SEL, '0, '0, 1'b1);
   endtask

   // points on the v axis: the quarter-turn angle gives zero height
   task automatic test_line_set();
      send_word(OP_ACC, '0, 32'h0010_0000, 1'b1);
      send_word(OP_ACC, '0, 32'hFFF0_0000, 1'b1);
      send_word(OP_SEL, '0, '0, 1'b1);
      send_word(OP_ROT, 32'h0001_0000, '0, 1'b1);
      send_word(OP_ROT, SAT_POS, SAT_POS, 1'b1);
   endtask

   task automatic test_extreme_points();
      send_word(OP_ACC, SAT_POS, SAT_POS, 1'b1);
      send_word(OP_ACC, SAT_NEG, SAT_NEG, 1'b1);
      send_word(OP_ACC, SAT_POS, SAT_NEG, 1'b1);
      send_word(OP_SEL, '0, '0, 1'b1);
      send_word(OP_ROT, SAT_POS, SAT_NEG, 1'b1);
      send_word(OP_ROT, SAT_NEG, SAT_NEG, 1'b1);
   endtask

   task automatic test_drain_pause();
      send_word(OP_ACC, 32'h0003_0000, 32'hFFFE_0000, 1'b1);
      send_word(OP_ACC, 32'hFFFD_0000, 32'h0004_0000, 1'b1);
      hold_until_drained();
      send_word(OP_SEL, '0, '0, 1'b1);
      hold_until_drained();
      send_word(OP_ROT, 32'h0002_0000, 32'h0001_0000, 1'b1);
   endtask

   task automatic test_random_sets(int n_items, int send_pct, int recv_pct);
      int sent, n_pts, n_rot;
      bit thin, real_pt;
      longint bu, bv, du, dv, t, pu, pv;
      logic [OP_W-1:0] op;
      logic [OP_W-1:0] op_codes [4];
      op_codes = '{OP_ACC, OP_SEL, OP_ROT, OP_NONE};
      sender_idle_pct = send_pct;
      receiver_idle_pct = recv_pct;
      sent = 0;
      while (sent < n_items) begin
         if ($urandom_range(99) < 85) begin
            n_pts = $urandom_range(1, 8);
            thin = 1'($urandom_range(1));
            bu = longint'($urandom_range(0, 32'h00FF_FFFF)) - 64'sh0080_0000;
            bv = longint'($urandom_range(0, 32'h00FF_FFFF)) - 64'sh0080_0000;
            du = longint'($urandom_range(0, 32'h0003_FFFF)) - 64'sh0002_0000;
            dv = longint'($urandom_range(0, 32'h0003_FFFF)) - 64'sh0002_0000;
            repeat (n_pts) begin
               real_pt = ($urandom_range(99) < 90);
               if (thin) begin
                  t = longint'($urandom_range(128)) - 64;
                  pu = bu + t * du + longint'($urandom_range(255)) - 128;
                  pv = bv + t * dv + longint'($urandom_range(255)) - 128;
                  send_word(OP_ACC, pu[PT_W-1:0], pv[PT_W-1:0], real_pt);
               end else begin
                  send_word(OP_ACC, rand_coord(), rand_coord(), real_pt);
               end
               if (real_pt) sent++;
            end
            send_word(OP_SEL, $urandom(), $urandom(), 1'($urandom_range(1)));
            sent++;
            n_rot = $urandom_range(1, 4);
            repeat (n_rot) begin
               send_word(OP_ROT, rand_coord(), rand_coord(), $urandom_range(99) < 85);
               sent++;
            end
         end else begin
            op = op_codes[2'($urandom_range(3))];
            real_pt = 1'($urandom_range(1));
            send_word(op, $urandom(), $urandom(), real_pt);
            if (op != OP_NONE && !(op == OP_ACC && !real_pt)) sent++;
         end
      end
   endtask

   initial begin
      build_trig();
      clear_sets();
      chosen = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      sender_idle_pct = 16;
      receiver_idle_pct = 80;
      test_identity_rotation();
      test_empty_select();
      test_tied_heights();
      test_line_set();
      test_extreme_points();
      test_drain_pause();
      test_random_sets(600, 16, 80);
      test_random_sets(600, 80, 16);
      test_random_sets(600, 0, 0);
      req_valid <= 1'b0;
      while (report_q.size() != 0) @(posedge clock);
      repeat (NUM_ROTATIONS + 10) @(posedge clock);
      if (fault_count == 0 && report_q.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

`default_nettype wire
